FILE: rtl/bfba_pkg.sv
package bfba_pkg;

   localparam int ArenaBytesDefault  = 1024;
   localparam int HeaderBytesDefault = 16;
   localparam int SizeW      = 11;
   localparam int OffsetW    = 10;
   localparam int KindW      = 2;
   localparam int StatusW    = 3;
   localparam logic [SizeW-1:0] ArenaSizeReset = 11'd1024;

   typedef enum logic [KindW-1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_REINIT = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [StatusW-1:0] {
      STAT_GRANTED = 3'd0,
      STAT_NOFIT   = 3'd1,
      STAT_FREED   = 3'd2,
      STAT_IGNORED = 3'd3,
      STAT_REINIT  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLR,
      ST_WALK,
      ST_AFIN,
      ST_ASPL,
      ST_FRD,
      ST_FR,
      ST_FL0,
      ST_FL1,
      ST_FL2,
      ST_FIX,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/bfba_ram.sv
module bfba_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/best_fit_block_allocator_unit.sv
// best-fit allocator: block headers live in one ram, one header read per cycle
// allocate: walks the block chain, then grants, splits or reports no fit; free: merges the
// freed block with free neighbours; reinitialise: the ram clearing sweep zeroes every header
// one request in flight at a time; the next is taken while a result waits in the output register
// reset: synchronous, the cycle after reset writes the header at offset zero, then idle
module best_fit_block_allocator_unit #(
   parameter int ARENA_BYTES  = bfba_pkg::ArenaBytesDefault,
   parameter int HEADER_BYTES = bfba_pkg::HeaderBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // request_size[10:0], block_offset[20:11], zero
   input  logic [2:0]  req_tuser,   // kind[1:0], offset_is_null[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[2:0], granted_offset[12:3], zero
   input  logic        csr_wr_en,
   input  logic [bfba_pkg::SizeW-1:0] csr_wr_data
);
   import bfba_pkg::*;

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int SW = AW + 1;
   localparam int CW = ((SW > SizeW) ? SW : SizeW) + 2;
   localparam int EW = 2 + 3 * SW;
   localparam logic [CW-1:0] Hdr   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] Arena = CW'(ARENA_BYTES);

   state_type state_ff, state_in, fix_ret_ff, fix_ret_in;
   logic [SizeW-1:0] arena_ff;
   logic [SW-1:0] live_ff, live_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [AW-1:0] best_ff, best_in, off_ff, off_in, l_addr_ff, l_addr_in;
   logic [AW-1:0] t_addr_ff, t_addr_in, clr_ff, clr_in;
   logic          found_ff, found_in, init_rsp_ff, init_rsp_in;
   logic [CW-1:0] least_ff, least_in, req_ff, req_in;
   logic [SW-1:0] b_total_ff, b_total_in, b_prev_ff, b_prev_in, b_next_ff, b_next_in;
   logic [SW-1:0] p_total_ff, p_total_in, p_prev_ff, p_prev_in, p_next_ff, p_next_in;
   logic [SW-1:0] l_total_ff, l_total_in, l_prev_ff, l_prev_in, l_next_ff, l_next_in;
   logic [SW-1:0] t_prev_ff, t_prev_in;
   status_type    res_stat_ff, res_stat_in;
   logic [OffsetW-1:0] res_off_ff, res_off_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [EW-1:0] wdata, rdata;

   logic          e_here, e_used;
   logic [SW-1:0] e_total, e_prev, e_next;
   logic [CW-1:0] tot_c, waste, nxt, clamp, calc_a, calc_b;
   kind_type      req_kind;

   function automatic logic [EW-1:0] pack(input logic h, input logic u, input logic [SW-1:0] t,
                                          input logic [SW-1:0] p, input logic [SW-1:0] n);
      pack = {h, u, t, p, n};
   endfunction

   bfba_ram #(.Width(EW), .Depth(ARENA_BYTES)) u_hdr_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_addr(raddr),
      .rd_data(rdata)
   );

   assign e_here  = rdata[EW-1];
   assign e_used  = rdata[EW-2];
   assign e_total = rdata[3*SW-1:2*SW];
   assign e_prev  = rdata[2*SW-1:SW];
   assign e_next  = rdata[SW-1:0];
   assign tot_c   = CW'(e_total);
   assign waste   = tot_c - req_ff;
   assign nxt     = CW'(pos_ff) + CW'(e_next);
   assign req_kind = kind_type'(req_tuser[1:0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (CW'(arena_ff) < Hdr) begin
         clamp = Hdr;
      end else if (CW'(arena_ff) > Arena) begin
         clamp = Arena;
      end else begin
         clamp = CW'(arena_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         arena_ff     <= ArenaSizeReset;
         rsp_valid_ff <= 1'b0;
         init_rsp_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            arena_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         init_rsp_ff  <= init_rsp_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      fix_ret_ff  <= fix_ret_in;
      live_ff     <= live_in;
      pos_ff      <= pos_in;
      best_ff     <= best_in;
      off_ff      <= off_in;
      l_addr_ff   <= l_addr_in;
      t_addr_ff   <= t_addr_in;
      clr_ff      <= clr_in;
      least_ff    <= least_in;
      req_ff      <= req_in;
      b_total_ff  <= b_total_in;
      b_prev_ff   <= b_prev_in;
      b_next_ff   <= b_next_in;
      p_total_ff  <= p_total_in;
      p_prev_ff   <= p_prev_in;
      p_next_ff   <= p_next_in;
      l_total_ff  <= l_total_in;
      l_prev_ff   <= l_prev_in;
      l_next_ff   <= l_next_in;
      t_prev_ff   <= t_prev_in;
      res_stat_ff <= res_stat_in;
      res_off_ff  <= res_off_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      fix_ret_in   = fix_ret_ff;
      live_in      = live_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      off_in       = off_ff;
      l_addr_in    = l_addr_ff;
      t_addr_in    = t_addr_ff;
      clr_in       = clr_ff;
      found_in     = found_ff;
      init_rsp_in  = init_rsp_ff;
      least_in     = least_ff;
      req_in       = req_ff;
      b_total_in   = b_total_ff;
      b_prev_in    = b_prev_ff;
      b_next_in    = b_next_ff;
      p_total_in   = p_total_ff;
      p_prev_in    = p_prev_ff;
      p_next_in    = p_next_ff;
      l_total_in   = l_total_ff;
      l_prev_in    = l_prev_ff;
      l_next_in    = l_next_ff;
      t_prev_in    = t_prev_ff;
      res_stat_in  = res_stat_ff;
      res_off_in   = res_off_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      we     = 1'b0;
      waddr  = '0;
      wdata  = '0;
      raddr  = '0;
      calc_a = '0;
      calc_b = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            live_in = SW'(clamp);
            we      = 1'b1;
            waddr   = '0;
            wdata   = pack(1'b1, 1'b0, SW'(clamp - Hdr), '0, '0);
            state_in = init_rsp_ff ? ST_DONE : ST_IDLE;
            init_rsp_in = 1'b0;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               req_in     = CW'(req_tdata[10:0]);
               off_in     = AW'(req_tdata[20:11]);
               res_off_in = '0;
               case (req_kind)
                  KIND_ALLOC: begin
                     raddr    = '0;
                     pos_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_WALK;
                  end
                  KIND_FREE: begin
                     if (req_tuser[2] || CW'(req_tdata[20:11]) >= CW'(live_ff)
                         || CW'(req_tdata[20:11]) >= Arena) begin
                        res_stat_in = STAT_IGNORED;
                        state_in    = ST_DONE;
                     end else begin
                        raddr    = AW'(req_tdata[20:11]);
                        state_in = ST_FRD;
                     end
                  end
                  KIND_REINIT: begin
                     clr_in   = '0;
                     state_in = ST_CLR;
                  end
                  default: begin
                     res_stat_in = STAT_NOFIT;
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(ARENA_BYTES - 1)) begin
               res_stat_in = STAT_REINIT;
               init_rsp_in = 1'b1;
               state_in    = ST_INIT;
            end
         end
         ST_WALK: begin
            // one header per cycle: the next address comes straight from the read data
            if (e_here && !e_used && tot_c >= req_ff && (!found_ff || waste < least_ff)) begin
               found_in   = 1'b1;
               least_in   = waste;
               best_in    = AW'(pos_ff);
               b_total_in = e_total;
               b_prev_in  = e_prev;
               b_next_in  = e_next;
            end
            if (e_here && e_next != '0 && nxt < CW'(live_ff)) begin
               raddr  = AW'(nxt);
               pos_in = SW'(nxt);
            end else begin
               state_in = ST_AFIN;
            end
         end
         ST_AFIN: begin
            calc_a = CW'(b_total_ff) - req_ff;
            calc_b = Hdr + req_ff;
            if (!found_ff) begin
               res_stat_in = STAT_NOFIT;
               state_in    = ST_DONE;
            end else if (calc_a > Hdr) begin
               // split: the tail becomes a new free block
               we    = 1'b1;
               waddr = AW'(CW'(best_ff) + calc_b);
               wdata = pack(1'b1, 1'b0, SW'(calc_a - Hdr), SW'(calc_b),
                            (b_next_ff != '0) ? SW'(CW'(b_next_ff) - calc_b) : '0);
               if (b_next_ff != '0) begin
                  raddr      = AW'(CW'(best_ff) + CW'(b_next_ff));
                  t_addr_in  = AW'(CW'(best_ff) + CW'(b_next_ff));
                  t_prev_in  = SW'(CW'(b_next_ff) - calc_b);
                  fix_ret_in = ST_ASPL;
                  state_in   = ST_FIX;
               end else begin
                  state_in = ST_ASPL;
               end
            end else begin
               we    = 1'b1;
               waddr = best_ff;
               wdata = pack(1'b1, 1'b1, b_total_ff, b_prev_ff, b_next_ff);
               res_stat_in = STAT_GRANTED;
               res_off_in  = OffsetW'(best_ff);
               state_in    = ST_DONE;
            end
         end
         ST_ASPL: begin
            calc_b = Hdr + req_ff;
            we    = 1'b1;
            waddr = best_ff;
            wdata = pack(1'b1, 1'b1, SW'(req_ff), b_prev_ff, SW'(calc_b));
            res_stat_in = STAT_GRANTED;
            res_off_in  = OffsetW'(best_ff);
            state_in    = ST_DONE;
         end
         ST_FRD: begin
            if (!e_here) begin
               res_stat_in = STAT_IGNORED;
               state_in    = ST_DONE;
            end else begin
               p_total_in = e_total;
               p_prev_in  = e_prev;
               p_next_in  = e_next;
               if (e_next != '0) begin
                  raddr    = AW'(CW'(off_ff) + CW'(e_next));
                  state_in = ST_FR;
               end else begin
                  state_in = ST_FL0;
               end
            end
         end
         ST_FR: begin
            state_in = ST_FL0;
            if (!e_used) begin
               we    = 1'b1;
               waddr = AW'(CW'(off_ff) + CW'(p_next_ff));
               wdata = pack(1'b0, e_used, e_total, e_prev, e_next);
               calc_a = CW'(p_total_ff) + Hdr + tot_c;
               calc_b = (e_next != '0) ? CW'(p_next_ff) + CW'(e_next) : '0;
               p_total_in = SW'(calc_a);
               p_next_in  = SW'(calc_b);
               if (calc_b != '0) begin
                  raddr      = AW'(CW'(off_ff) + calc_b);
                  t_addr_in  = AW'(CW'(off_ff) + calc_b);
                  t_prev_in  = SW'(calc_b);
                  fix_ret_in = ST_FL0;
                  state_in   = ST_FIX;
               end
            end
         end
         ST_FL0: begin
            if (p_prev_ff != '0) begin
               raddr     = AW'(CW'(off_ff) - CW'(p_prev_ff));
               l_addr_in = AW'(CW'(off_ff) - CW'(p_prev_ff));
               state_in  = ST_FL1;
            end else begin
               we    = 1'b1;
               waddr = off_ff;
               wdata = pack(1'b1, 1'b0, p_total_ff, p_prev_ff, p_next_ff);
               res_stat_in = STAT_FREED;
               state_in    = ST_DONE;
            end
         end
         ST_FL1: begin
            we    = 1'b1;
            waddr = off_ff;
            res_stat_in = STAT_FREED;
            if (!e_used) begin
               // left neighbour absorbs this block
               wdata  = pack(1'b0, 1'b0, p_total_ff, p_prev_ff, p_next_ff);
               calc_a = tot_c + Hdr + CW'(p_total_ff);
               l_total_in = SW'(calc_a);
               l_prev_in  = e_prev;
               l_next_in  = (p_next_ff != '0) ? SW'(Hdr + calc_a) : '0;
               state_in   = ST_FL2;
            end else begin
               wdata    = pack(1'b1, 1'b0, p_total_ff, p_prev_ff, p_next_ff);
               state_in = ST_DONE;
            end
         end
         ST_FL2: begin
            we    = 1'b1;
            waddr = l_addr_ff;
            wdata = pack(1'b1, 1'b0, l_total_ff, l_prev_ff, l_next_ff);
            state_in = ST_DONE;
            if (l_next_ff != '0) begin
               raddr      = AW'(CW'(l_addr_ff) + CW'(l_next_ff));
               t_addr_in  = AW'(CW'(l_addr_ff) + CW'(l_next_ff));
               t_prev_in  = l_next_ff;
               fix_ret_in = ST_DONE;
               state_in   = ST_FIX;
            end
         end
         ST_FIX: begin
            // relink the back distance of the block that follows
            we    = 1'b1;
            waddr = t_addr_ff;
            wdata = pack(e_here, e_used, e_total, t_prev_ff, e_next);
            state_in = fix_ret_ff;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_off_ff, res_stat_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
